// ===== src/yprx_pkg.sv =====
// Shared types and codes for the YMODEM packet receiver.
`default_nettype none
package yprx_pkg;

  // Control bytes seen on the link
  localparam logic [7:0] CODE_SOH    = 8'h01;
  localparam logic [7:0] CODE_STX    = 8'h02;
  localparam logic [7:0] CODE_EOT    = 8'h04;
  localparam logic [7:0] CODE_CAN    = 8'h18;
  localparam logic [7:0] CODE_ABORTU = 8'h41;
  localparam logic [7:0] CODE_ABORTL = 8'h61;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Count of bytes after the start byte at which the high CRC byte arrives
  localparam logic [10:0] CRC_HI_POS_SMALL = 11'd130;
  localparam logic [10:0] CRC_HI_POS_LARGE = 11'd1026;

  typedef enum logic [3:0] {
    ST_BUSY     = 4'd0,
    ST_OK       = 4'd1,
    ST_EOT      = 4'd2,
    ST_CANCEL   = 4'd3,
    ST_ABORT    = 4'd4,
    ST_TIMEOUT  = 4'd5,
    ST_BADSTART = 4'd6,
    ST_LONECAN  = 4'd7,
    ST_SEQERR   = 4'd8,
    ST_CRCERR   = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_CANCEL = 3'b010,
    PH_PACKET = 3'b100
  } phase_e;

  typedef struct packed {
    status_e     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  block_number;
    logic        large_block;
  } result_t;

endpackage
`default_nettype wire

// ===== src/ymodem_packet_receiver_core.sv =====
// YMODEM packet receiver: deframes SOH/STX blocks and checks CRC-16/XMODEM.
//
// Each transfer on the input carries one event: a received byte (action_i = 0)
// or a byte timeout (action_i = 1). Every event yields exactly one result:
// status 0 (busy) while a packet is in progress, payload bytes flagged by
// payload_valid_o with their index in the block, and a final status on the
// low CRC byte (1 ok, 8 sequence complement error, 9 CRC error) with the
// block number. EOT, cancel, lone cancel, abort, bad start and timeout end
// things with their own codes; the block then returns to idle. Throughput is
// one event per clock while in_ready_o is high: the CRC is updated a whole
// byte per cycle in the deframer. Results are registered in a two-entry result
// buffer that keeps input ready (a registered signal) while one result waits.
`default_nettype none
module ymodem_packet_receiver_core
  import yprx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       action_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      status_o,
  output logic            payload_valid_o,
  output logic [7:0]      payload_byte_o,
  output logic [9:0]      payload_index_o,
  output logic [7:0]      block_number_o,
  output logic            large_block_o
);

  logic    accept;
  result_t res_new, res_out;

  assign accept = in_valid_i && in_ready_o;

  yprx_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .action_i  (action_i),
    .rx_byte_i (rx_byte_i),
    .result_o  (res_new)
  );

  yprx_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res_new),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_out)
  );

  assign status_o        = res_out.status;
  assign payload_valid_o = res_out.payload_valid;
  assign payload_byte_o  = res_out.payload_byte;
  assign payload_index_o = res_out.payload_index;
  assign block_number_o  = res_out.block_number;
  assign large_block_o   = res_out.large_block;

  // Payload bytes only show up while a packet is still open
  a_payload_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> status_o == ST_BUSY)
    else $error("payload byte with a final status");

  // Block number is reported only with a packet-closing status
  a_blknum_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_number_o != 8'd0 |->
      (status_o == ST_OK || status_o == ST_SEQERR || status_o == ST_CRCERR))
    else $error("block number outside packet end");

  // Input stalls only when both buffer entries hold results
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule
`default_nettype wire

// ===== src/yprx_crc.sv =====
// Bytewise CRC-16/XMODEM update (poly 0x1021, MSB first).
`default_nettype none
module yprx_crc
  import yprx_pkg::*;
(
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule
`default_nettype wire

// ===== src/yprx_deframer.sv =====
// Packet deframing state machine: one event per transfer, one result out.
`default_nettype none
module yprx_deframer
  import yprx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       action_i,
  input  wire logic [7:0] rx_byte_i,
  output result_t         result_o
);

  phase_e      phase_q, phase_d;
  logic [10:0] byte_count_q, byte_count_d;
  logic        size_flag_q, size_flag_d;
  logic [7:0]  seq_value_q, seq_value_d;
  logic [7:0]  seq_inverse_q, seq_inverse_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_upper_q, crc_upper_d;

  logic [15:0] crc_next;
  logic [10:0] crc_hi_pos;
  logic [10:0] pay_offset;
  logic        is_timeout;

  yprx_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (rx_byte_i),
    .crc_o  (crc_next)
  );

  assign is_timeout = action_i;
  assign crc_hi_pos = size_flag_q ? CRC_HI_POS_LARGE : CRC_HI_POS_SMALL;
  assign pay_offset = byte_count_q - 11'd2;

  always_comb begin
    phase_d       = phase_q;
    byte_count_d  = byte_count_q;
    size_flag_d   = size_flag_q;
    seq_value_d   = seq_value_q;
    seq_inverse_d = seq_inverse_q;
    crc_d         = crc_q;
    crc_upper_d   = crc_upper_q;
    result_o      = '0;
    result_o.status = ST_BUSY;

    case (phase_q)
      PH_CANCEL: begin
        result_o.status = (!is_timeout && rx_byte_i == CODE_CAN) ? ST_CANCEL : ST_LONECAN;
        phase_d = PH_IDLE;
      end
      PH_PACKET: begin
        result_o.large_block = size_flag_q;
        if (is_timeout) begin
          result_o.status = ST_TIMEOUT;
          phase_d = PH_IDLE;
        end else if (byte_count_q == 11'd0) begin
          seq_value_d  = rx_byte_i;
          byte_count_d = 11'd1;
        end else if (byte_count_q == 11'd1) begin
          seq_inverse_d = rx_byte_i;
          byte_count_d  = 11'd2;
        end else if (byte_count_q < crc_hi_pos) begin
          result_o.payload_valid = 1'b1;
          result_o.payload_byte  = rx_byte_i;
          result_o.payload_index = pay_offset[9:0];
          crc_d        = crc_next;
          byte_count_d = byte_count_q + 11'd1;
        end else if (byte_count_q == crc_hi_pos) begin
          crc_upper_d  = rx_byte_i;
          byte_count_d = byte_count_q + 11'd1;
        end else begin
          // Low CRC byte closes the packet; complement check wins over CRC
          result_o.block_number = seq_value_q;
          if (seq_value_q != ~seq_inverse_q) begin
            result_o.status = ST_SEQERR;
          end else if ({crc_upper_q, rx_byte_i} != crc_q) begin
            result_o.status = ST_CRCERR;
          end else begin
            result_o.status = ST_OK;
          end
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (is_timeout) begin
          result_o.status = ST_TIMEOUT;
        end else begin
          case (rx_byte_i)
            CODE_SOH, CODE_STX: begin
              size_flag_d          = (rx_byte_i == CODE_STX);
              result_o.large_block = (rx_byte_i == CODE_STX);
              byte_count_d         = '0;
              crc_d                = '0;
              phase_d              = PH_PACKET;
            end
            CODE_EOT:                 result_o.status = ST_EOT;
            CODE_CAN:                 phase_d = PH_CANCEL;
            CODE_ABORTU, CODE_ABORTL: result_o.status = ST_ABORT;
            default:                  result_o.status = ST_BADSTART;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      byte_count_q  <= '0;
      size_flag_q   <= 1'b0;
      seq_value_q   <= '0;
      seq_inverse_q <= '0;
      crc_q         <= '0;
      crc_upper_q   <= '0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      byte_count_q  <= byte_count_d;
      size_flag_q   <= size_flag_d;
      seq_value_q   <= seq_value_d;
      seq_inverse_q <= seq_inverse_d;
      crc_q         <= crc_d;
      crc_upper_q   <= crc_upper_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/yprx_outbuf.sv =====
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module yprx_outbuf
  import yprx_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      data_o
);

  logic    main_vld_q, skid_vld_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop     = main_vld_q && ready_i;
  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        main_vld_q <= push_i;
      end
    end else if (push_i) begin
      if (!main_vld_q) begin
        main_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  // Payload path: no reset
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      if (!main_vld_q) begin
        main_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/ymodem_packet_receiver_checker.sv =====
// Result predictor and scoreboard for the YMODEM packet receiver core.
`timescale 1ns / 100ps

package yprx_tb_pkg;
  import yprx_pkg::*;

  // Bytewise CRC-16/XMODEM update, MSB first
  function automatic logic [15:0] crc16_xmodem_add(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction
endpackage

module ymodem_packet_receiver_checker
  import yprx_pkg::*;
  import yprx_tb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [3:0] status_i,
  input  logic       payload_valid_i,
  input  logic [7:0] payload_byte_i,
  input  logic [9:0] payload_index_i,
  input  logic [7:0] block_number_i,
  input  logic       large_block_i,
  output int         mismatches_o,
  output int         pending_o
);

  // Deframer state as predicted
  phase_e      frame_phase = PH_IDLE;
  logic [10:0] rx_count    = '0;
  logic        big_blk     = 1'b0;
  logic [7:0]  seq_num     = '0;
  logic [7:0]  seq_cpl     = '0;
  logic [15:0] crc_acc     = '0;
  logic [7:0]  crc_hi      = '0;

  result_t     expected_q[$];
  result_t     want;
  int          mism_cnt = 0;
  int          queued   = 0;

  assign mismatches_o = mism_cnt;
  assign pending_o    = queued;

  function automatic result_t frame_event(input logic is_timeout, input logic [7:0] b);
    result_t     r;
    logic [10:0] crc_hi_pos;
    r = '0;
    r.status = ST_BUSY;
    crc_hi_pos = big_blk ? CRC_HI_POS_LARGE : CRC_HI_POS_SMALL;
    case (frame_phase)
      PH_CANCEL: begin
        r.status = (!is_timeout && b == CODE_CAN) ? ST_CANCEL : ST_LONECAN;
        frame_phase = PH_IDLE;
      end
      PH_PACKET: begin
        r.large_block = big_blk;
        if (is_timeout) begin
          r.status = ST_TIMEOUT;
          frame_phase = PH_IDLE;
        end else if (rx_count == 11'd0) begin
          seq_num = b;
          rx_count = 11'd1;
        end else if (rx_count == 11'd1) begin
          seq_cpl = b;
          rx_count = 11'd2;
        end else if (rx_count < crc_hi_pos) begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          r.payload_index = 10'(rx_count - 11'd2);
          crc_acc = crc16_xmodem_add(crc_acc, b);
          rx_count = rx_count + 11'd1;
        end else if (rx_count == crc_hi_pos) begin
          crc_hi = b;
          rx_count = rx_count + 11'd1;
        end else begin
          // low CRC byte closes the packet; complement is checked first
          r.block_number = seq_num;
          if (seq_num != ~seq_cpl) r.status = ST_SEQERR;
          else if ({crc_hi, b} != crc_acc) r.status = ST_CRCERR;
          else r.status = ST_OK;
          frame_phase = PH_IDLE;
        end
      end
      default: begin
        frame_phase = PH_IDLE;
        if (is_timeout) begin
          r.status = ST_TIMEOUT;
        end else if (b == CODE_SOH || b == CODE_STX) begin
          big_blk = (b == CODE_STX);
          r.large_block = big_blk;
          rx_count = '0;
          crc_acc = '0;
          frame_phase = PH_PACKET;
        end else if (b == CODE_EOT) begin
          r.status = ST_EOT;
        end else if (b == CODE_CAN) begin
          frame_phase = PH_CANCEL;
        end else if (b == CODE_ABORTU || b == CODE_ABORTL) begin
          r.status = ST_ABORT;
        end else begin
          r.status = ST_BADSTART;
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [15:0] exp_v,
                            input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, exp_v, got_v);
      mism_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_phase = PH_IDLE;
      rx_count = '0;
      big_blk = 1'b0;
      seq_num = '0;
      seq_cpl = '0;
      crc_acc = '0;
      crc_hi = '0;
      expected_q.delete();
      mism_cnt = 0;
      queued = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(frame_event(action_i, rx_byte_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, status %0h",
                   $time, status_i);
          mism_cnt++;
        end else begin
          want = expected_q.pop_front();
          flag_field("status", 16'(want.status), 16'(status_i));
          flag_field("payload_valid", 16'(want.payload_valid), 16'(payload_valid_i));
          flag_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte_i));
          flag_field("payload_index", 16'(want.payload_index), 16'(payload_index_i));
          flag_field("block_number", 16'(want.block_number), 16'(block_number_i));
          flag_field("large_block", 16'(want.large_block), 16'(large_block_i));
        end
      end
      queued = expected_q.size();
    end
  end

endmodule

// ===== tb/ymodem_packet_receiver_core_test.sv =====
// Stimulus, clock, reset and verdict for the YMODEM packet receiver core.
`timescale 1ns / 100ps

module ymodem_packet_receiver_core_test;
  import yprx_pkg::*;
  import yprx_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_AT         = 300;   // result count at which the sink backs off
  localparam int HOLD_CYCLES     = 300;
  localparam int TOTAL_ITEMS     = 500;
  localparam int SMALL_PKT_ITEMS = 133;   // start, seq, complement, 128 payload, 2 CRC
  localparam int CUT_SPAN        = 131;   // a cut packet stops within a small block's length

  typedef enum {PKT_GOOD, PKT_BAD_CPL, PKT_BAD_CRC, PKT_BAD_BOTH, PKT_CUT} pkt_flaw_e;

  logic       clk_i     = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       action    = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_ready = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [3:0] status;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [9:0] payload_index;
  logic [7:0] block_number;
  logic       large_block;

  int         mismatches;
  int         outstanding;
  int         sent   = 0;
  int         taken  = 0;
  int         cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ymodem_packet_receiver_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .payload_valid_o(payload_valid),
    .payload_byte_o (payload_byte),
    .payload_index_o(payload_index),
    .block_number_o (block_number),
    .large_block_o  (large_block)
  );

  ymodem_packet_receiver_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .action_i       (action),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .payload_valid_i(payload_valid),
    .payload_byte_i (payload_byte),
    .payload_index_i(payload_index),
    .block_number_i (block_number),
    .large_block_i  (large_block),
    .mismatches_o   (mismatches),
    .pending_o      (outstanding)
  );

  // Every third run of 64 transfers goes without idle cycles
  function automatic int pick_wait(input int n);
    if ((n / 64) % 3 == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_event(input logic is_timeout, input logic [7:0] b);
    int gap;
    gap = pick_wait(sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= is_timeout;
    rx_byte <= b;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_event(1'b0, b);
  endtask

  task automatic send_timeout();
    send_event(1'b1, 8'($urandom));
  endtask

  task automatic send_packet(input logic big, input pkt_flaw_e flaw);
    int          len;
    int          cut_at;
    int          fill;
    logic [7:0]  seq;
    logic [7:0]  d;
    logic [15:0] crc;
    len = big ? 1024 : 128;
    cut_at = (flaw == PKT_CUT) ? $urandom_range(0, CUT_SPAN) : len + 4;
    seq = 8'($urandom_range(0, 255));
    fill = $urandom_range(0, 7);
    crc = '0;
    put_byte(big ? CODE_STX : CODE_SOH);
    for (int pos = 0; pos < len + 4; pos++) begin
      if (pos == cut_at) begin
        send_timeout();
        return;
      end
      if (pos == 0) begin
        d = seq;
      end else if (pos == 1) begin
        d = ~seq;
        if (flaw == PKT_BAD_CPL || flaw == PKT_BAD_BOTH) d = d ^ 8'($urandom_range(1, 255));
      end else if (pos < len + 2) begin
        d = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : 8'($urandom);
        crc = crc16_xmodem_add(crc, d);
      end else if (pos == len + 2) begin
        if (flaw == PKT_BAD_CRC || flaw == PKT_BAD_BOTH) crc = crc ^ 16'($urandom_range(1, 65535));
        d = crc[15:8];
      end else begin
        d = crc[7:0];
      end
      put_byte(d);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_timeout();
      1: begin
        put_byte(CODE_CAN);
        put_byte(CODE_CAN);
      end
      2: begin
        put_byte(CODE_CAN);
        if ($urandom_range(0, 1)) send_timeout();
        else put_byte(8'($urandom));
      end
      3: put_byte($urandom_range(0, 1) ? CODE_ABORTU : CODE_ABORTL);
      default: put_byte(8'($urandom));
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // idle-state codes and the cancel wait
    send_timeout();
    put_byte(CODE_EOT);
    put_byte(CODE_CAN);
    put_byte(CODE_CAN);
    put_byte(CODE_CAN);
    put_byte(8'h00);
    put_byte(CODE_CAN);
    send_timeout();
    put_byte(CODE_CAN);
    put_byte(CODE_SOH);      // swallowed as a lone cancel
    put_byte(CODE_ABORTU);
    put_byte(CODE_ABORTL);
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(8'h03);
    put_byte(CODE_SOH);
    send_timeout();           // timeout right after the start byte
    put_byte(8'h80);

    // packet endings, a large packet cut short, then a random mix up to the item budget
    send_packet(1'b0, PKT_GOOD);
    send_packet(1'b0, PKT_BAD_BOTH);
    send_packet(1'b0, PKT_BAD_CRC);
    send_packet(1'b1, PKT_CUT);
    while (sent < TOTAL_ITEMS) begin
      if (TOTAL_ITEMS - sent >= SMALL_PKT_ITEMS && $urandom_range(0, 99) < 60) begin
        case ($urandom_range(0, 9))
          5: send_packet(1'b0, PKT_BAD_CPL);
          6: send_packet(1'b0, PKT_BAD_CRC);
          7: send_packet(1'b0, PKT_BAD_BOTH);
          8, 9: send_packet(1'b0, PKT_CUT);
          default: send_packet(1'b0, PKT_GOOD);
        endcase
      end else begin
        send_noise();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result sink: random stalls, plus one long back-off to fill the block
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (taken == HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = pick_wait(taken + 32);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
src/yprx_pkg.sv
src/yprx_crc.sv
src/yprx_deframer.sv
src/yprx_outbuf.sv
src/ymodem_packet_receiver_core.sv
tb/ymodem_packet_receiver_checker.sv
tb/ymodem_packet_receiver_core_test.sv
